FILE: rtl/lru_page_replacement_core_assert.svh
// Assertion macros used by the page store frame array (lrupr_frames).
`ifndef LRU_PAGE_REPLACEMENT_CORE_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LRUPR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define LRUPR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/lrupr_pkg.sv
`timescale 1ns / 1ps

package lrupr_pkg;

   localparam int PAGE_W = 20;
   localparam int OCC_W  = 3;

   typedef struct packed {
      logic              hit;
      logic              evicted;
      logic [PAGE_W-1:0] evicted_page;
      logic [OCC_W-1:0]  occupancy;
   } lrupr_result_type;

endpackage

FILE: rtl/lrupr_frames.sv
`timescale 1ns / 1ps
`include "lru_page_replacement_core_assert.svh"

module lrupr_frames
   import lrupr_pkg::*;
#(
   parameter int FRAMES    = 4,
   parameter int PAGE_BITS = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 update,
   input  logic [PAGE_BITS-1:0] page,
   output lrupr_result_type     result
);

   localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int CNT_W  = $clog2(FRAMES + 1);

   logic [PAGE_BITS-1:0] tag_ff [FRAMES];
   logic [FRAMES-1:0]    valid_ff;
   logic [FRAMES-1:0]    valid_in;
   logic [RANK_W-1:0]    rank_ff [FRAMES];
   logic [RANK_W-1:0]    rank_in [FRAMES];
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;

   logic [FRAMES-1:0] hit_vec;
   logic              hit;
   logic              full;
   logic              evict;
   logic [IDX_W-1:0]  hit_idx;
   logic [IDX_W-1:0]  free_idx;
   logic [IDX_W-1:0]  victim_idx;
   logic [IDX_W-1:0]  slot;
   logic [RANK_W-1:0] hit_rank;
   logic [PAGE_BITS-1:0] victim_tag;
   logic [PAGE_W-1:0]    victim_page;
   logic [OCC_W-1:0]     occ;

   always_comb begin
      hit_idx    = '0;
      free_idx   = '0;
      victim_idx = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         hit_vec[i] = valid_ff[i] && (tag_ff[i] == page);
         if (hit_vec[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
         // valid ranks form a permutation when full, so the oldest is unique
         if (rank_ff[i] == RANK_W'(FRAMES - 1)) begin
            victim_idx = IDX_W'(i);
         end
      end
      hit      = |hit_vec;
      full     = (count_ff == CNT_W'(FRAMES));
      evict    = !hit && full;
      hit_rank = rank_ff[hit_idx];
      if (hit) begin
         slot = hit_idx;
      end else if (full) begin
         slot = victim_idx;
      end else begin
         slot = free_idx;
      end
      victim_tag = tag_ff[victim_idx];
   end

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      if (!hit) begin
         valid_in[slot] = 1'b1;
         if (!full) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      for (int i = 0; i < FRAMES; i++) begin
         if (IDX_W'(i) == slot) begin
            rank_in[i] = '0;
         end else if (valid_ff[i] && (!hit || (rank_ff[i] < hit_rank))) begin
            rank_in[i] = rank_ff[i] + RANK_W'(1);
         end else begin
            rank_in[i] = rank_ff[i];
         end
      end
   end

   generate
      if (PAGE_BITS >= PAGE_W) begin : g_ev_trunc
         assign victim_page = victim_tag[PAGE_W-1:0];
      end else begin : g_ev_ext
         assign victim_page = {{(PAGE_W - PAGE_BITS){1'b0}}, victim_tag};
      end
      if (CNT_W >= OCC_W) begin : g_occ_trunc
         assign occ = count_in[OCC_W-1:0];
      end else begin : g_occ_ext
         assign occ = {{(OCC_W - CNT_W){1'b0}}, count_in};
      end
   endgenerate

   assign result.hit          = hit;
   assign result.evicted      = evict;
   assign result.evicted_page = evict ? victim_page : '0;
   assign result.occupancy    = occ;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < FRAMES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (update) begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int i = 0; i < FRAMES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // install the referenced page on a miss
   always_ff @(posedge clock) begin
      if (update && !hit) begin
         tag_ff[slot] <= page;
      end
   end

   `LRUPR_ASSERT_NOW(a_count_tracks_valid, clock, reset, 1'b1,
      $countones(valid_ff) == int'(count_ff), "frame count disagrees with valid marks")
   `LRUPR_ASSERT_NOW(a_evict_only_when_full, clock, reset, evict,
      valid_ff[victim_idx] && (&valid_ff), "eviction while a frame is free")
   `LRUPR_ASSERT_NEXT(a_hit_keeps_count, clock, reset, update && hit,
      $stable(count_ff) && $stable(valid_ff), "hit changed occupancy")

endmodule

FILE: rtl/lrupr_rsp_reg.sv
`timescale 1ns / 1ps

module lrupr_rsp_reg
   import lrupr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  lrupr_result_type  in_result,
   output logic              advance,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_hit,
   output logic              rsp_evicted,
   output logic [PAGE_W-1:0] rsp_evicted_page,
   output logic [OCC_W-1:0]  rsp_occupancy
);

   logic             valid_ff;
   lrupr_result_type result_ff;

   // move on when the slot is empty or its transfer completes this cycle
   assign advance = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         result_ff <= in_result;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_hit          = result_ff.hit;
   assign rsp_evicted      = result_ff.evicted;
   assign rsp_evicted_page = result_ff.evicted_page;
   assign rsp_occupancy    = result_ff.occupancy;

endmodule

FILE: rtl/lru_page_replacement_core.sv
// Fully associative LRU page store.
// Request channel: req_valid / req_stall carry one page reference per transfer
// (req_page). Response channel: rsp_valid / rsp_stall carry exactly one result
// per request: rsp_hit, rsp_evicted, rsp_evicted_page (zero unless evicted)
// and rsp_occupancy, the number of occupied frames after the access.
// A request is held in the request register, looked up from there, and its
// result is captured in the response register that drives the response ports.
// Throughput: one reference per cycle unless the receiver stalls; the tag
// compare, victim select and rank update of all frames are done in parallel
// between the request register and the response register.
// When the receiver stalls, the response register holds its result; the
// request register keeps one more reference and then req_stall rises until
// the response transfer completes.
// Reset (synchronous, active high) empties the store: all frames invalid,
// ranks and occupancy zero, both registers empty. No clearing pass is needed.
`timescale 1ns / 1ps

module lru_page_replacement_core
   import lrupr_pkg::*;
#(
   parameter int FRAMES    = 4,
   parameter int PAGE_BITS = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [PAGE_W-1:0] req_page,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_hit,
   output logic              rsp_evicted,
   output logic [PAGE_W-1:0] rsp_evicted_page,
   output logic [OCC_W-1:0]  rsp_occupancy
);

   logic                 req_valid_ff;
   logic [PAGE_BITS-1:0] req_page_ff;
   logic [PAGE_BITS-1:0] page_tag;
   logic                 advance;
   lrupr_result_type     result;

   generate
      if (PAGE_BITS <= PAGE_W) begin : g_pg_trunc
         assign page_tag = req_page[PAGE_BITS-1:0];
      end else begin : g_pg_ext
         assign page_tag = {{(PAGE_BITS - PAGE_W){1'b0}}, req_page};
      end
   endgenerate

   assign req_stall = req_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_page_ff <= page_tag;
      end
   end

   lrupr_frames #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) u_frames (
      .clock  (clock),
      .reset  (reset),
      .update (req_valid_ff && advance),
      .page   (req_page_ff),
      .result (result)
   );

   lrupr_rsp_reg u_rsp_reg (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_valid_ff),
      .in_result        (result),
      .advance          (advance),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_evicted      (rsp_evicted),
      .rsp_evicted_page (rsp_evicted_page),
      .rsp_occupancy    (rsp_occupancy)
   );

endmodule

FILE: tb/lru_page_replacement_core_tb.sv
`timescale 1ns / 1ps

module lru_page_replacement_core_tb;
   import lrupr_pkg::*;

   localparam int FRAMES = 4;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [PAGE_W-1:0] req_page;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_hit;
   logic              rsp_evicted;
   logic [PAGE_W-1:0] rsp_evicted_page;
   logic [OCC_W-1:0]  rsp_occupancy;

   // Shadow copy of the page store.
   logic [PAGE_W-1:0] page_tag[FRAMES];
   logic              page_valid[FRAMES];
   int unsigned       page_rank[FRAMES];

   lrupr_result_type  pending_results[$];
   lrupr_result_type  want;
   logic [PAGE_W-1:0] recent_pages[$];
   int                error_count = 0;
   bit                idle_on = 1'b1;

   lru_page_replacement_core #(
      .FRAMES(FRAMES),
      .PAGE_BITS(PAGE_W)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_page(req_page),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_hit(rsp_hit),
      .rsp_evicted(rsp_evicted),
      .rsp_evicted_page(rsp_evicted_page),
      .rsp_occupancy(rsp_occupancy)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic void clear_store();
      for (int i = 0; i < FRAMES; i++) begin
         page_tag[i]   = '0;
         page_valid[i] = 1'b0;
         page_rank[i]  = 0;
      end
   endfunction

   // Look up one page, update the shadow store and return the result it causes.
   function automatic lrupr_result_type lru_lookup(input logic [PAGE_W-1:0] pg);
      lrupr_result_type r;
      int               slot;
      int unsigned      oldest;
      int               used;
      r = '0;
      slot = -1;
      for (int i = 0; i < FRAMES; i++)
         if (slot < 0 && page_valid[i] && page_tag[i] == pg) slot = i;
      if (slot >= 0) begin
         r.hit = 1'b1;
         for (int i = 0; i < FRAMES; i++)
            if (page_valid[i] && page_rank[i] < page_rank[slot]) page_rank[i]++;
         page_rank[slot] = 0;
      end else begin
         for (int i = 0; i < FRAMES; i++)
            if (slot < 0 && !page_valid[i]) slot = i;
         if (slot < 0) begin
            // Full: the oldest frame goes, lowest index on a tie.
            oldest = 0;
            slot = 0;
            for (int i = 0; i < FRAMES; i++) begin
               if (page_rank[i] > oldest) begin
                  oldest = page_rank[i];
                  slot = i;
               end
            end
            r.evicted      = 1'b1;
            r.evicted_page = page_tag[slot];
            page_valid[slot] = 1'b0;
         end
         for (int i = 0; i < FRAMES; i++)
            if (page_valid[i]) page_rank[i]++;
         page_tag[slot]   = pg;
         page_valid[slot] = 1'b1;
         page_rank[slot]  = 0;
      end
      used = 0;
      for (int i = 0; i < FRAMES; i++)
         if (page_valid[i]) used++;
      r.occupancy = used[OCC_W-1:0];
      return r;
   endfunction

   task automatic send_page(input logic [PAGE_W-1:0] pg);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_page  <= pg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // Transfer taken at this edge.
      pending_results.push_back(lru_lookup(pg));
      recent_pages.push_front(pg);
      if (recent_pages.size() > 6) void'(recent_pages.pop_back());
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Receiver stalls in random bursts.
   initial begin : rsp_stall_gen
      int n;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 6);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with nothing pending");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_hit !== want.hit) begin
               $error("hit: expected %0d, actual %0d", want.hit, rsp_hit);
               error_count++;
            end
            if (rsp_evicted !== want.evicted) begin
               $error("evicted: expected %0d, actual %0d", want.evicted, rsp_evicted);
               error_count++;
            end
            if (rsp_evicted_page !== want.evicted_page) begin
               $error("evicted_page: expected %h, actual %h",
                      want.evicted_page, rsp_evicted_page);
               error_count++;
            end
            if (rsp_occupancy !== want.occupancy) begin
               $error("occupancy: expected %0d, actual %0d", want.occupancy, rsp_occupancy);
               error_count++;
            end
         end
      end
   end

   // Extremes, fill, hits at each rank, eviction, near-miss tags.
   task automatic test_directed();
      send_page(20'h00000);
      send_page(20'h00000);
      send_page(20'hFFFFF);
      send_page(20'h00001);
      send_page(20'h7FFFF);
      send_page(20'hFFFFF);
      send_page(20'h80000);
      send_page(20'h55555);
      send_page(20'hAAAAA);
      send_page(20'h00000);
      send_page(20'hAAAAA);
      send_page(20'h80000);
      send_page(20'h55555);
      send_page(20'h00000);
      send_page(20'hFFFFE);
      send_page(20'hFFFFF);
      send_page(20'h00000);
   endtask

   // Small working set slightly larger or smaller than the store.
   task automatic test_hot_set(input int count);
      logic [PAGE_W-1:0] pool[8];
      logic [PAGE_W-1:0] base;
      int                pool_size;
      for (int k = 0; k < count; k++) begin
         if (k % 60 == 0) begin
            pool_size = $urandom_range(2, 8);
            base = PAGE_W'($urandom_range(0, 20'hFFFFF));
            for (int j = 0; j < 8; j++)
               pool[j] = ($urandom_range(0, 1) == 0) ?
                         base ^ (20'h1 << $urandom_range(0, PAGE_W - 1)) :
                         PAGE_W'($urandom_range(0, 20'hFFFFF));
         end
         if ($urandom_range(0, 9) == 0)
            send_page(PAGE_W'($urandom_range(0, 20'hFFFFF)));
         else
            send_page(pool[3'($urandom_range(0, pool_size - 1))]);
      end
   endtask

   // Wide random pages with some reuse of recent ones.
   task automatic test_wide_random(input int count);
      for (int k = 0; k < count; k++) begin
         if (recent_pages.size() != 0 && $urandom_range(0, 3) == 0)
            send_page(recent_pages[$urandom_range(0, recent_pages.size() - 1)]);
         else
            send_page(PAGE_W'($urandom_range(0, 20'hFFFFF)));
      end
   endtask

   // Hold the sender until the block has drained, then carry on.
   task automatic test_drain_pause();
      test_hot_set(40);
      wait_for_results();
      test_wide_random(40);
   endtask

   // Back-to-back traffic with no idling on either side.
   task automatic test_streaming(input int count);
      idle_on = 1'b0;
      test_hot_set(count);
   endtask

   initial begin
      req_valid <= 1'b0;
      req_page  <= '0;
      reset     <= 1'b1;
      clear_store();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_hot_set(900);
      test_wide_random(360);
      test_drain_pause();
      test_streaming(300);

      wait_for_results();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
